### rtl/aes_pkg.sv
// Package for the AES-128 encryption pipeline: payload types, S-box and
// round-function helpers. No dependencies.
package aes_pkg;

    localparam int NumRounds = 10;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_beat_t;

    // Data and key travelling together through one pipeline cell.
    typedef struct packed {
        logic         valid;
        logic [127:0] state;
        logic [127:0] rkey;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block sits at bits 127-8i downto 120-8i.
    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

endpackage

### rtl/aes128_block_encrypt.sv
// Top level of the AES-128 encryption pipeline: key registers, entry cell
// and a chain of ten round cells. Depends on aes_pkg and aes_round_cell.
//
// Usage: the key is written through the cfg port (index 0 = key bytes 0..7,
// index 1 = key bytes 8..15) while the pipeline is empty. Plaintext beats
// enter on in_valid/in_ready, ciphertext beats leave on out_valid/out_ready.
// Each beat carries one full 128-bit block; the cipher key rides along
// with the block and each cell derives the next round key, so no key
// expansion pass is needed after a key write.
// Cells: one entry cell for the initial AddRoundKey, then one per round.
// Throughput: one block per cycle while the output is not held; every cell holds one block.
// Stall: the whole chain advances together. When the output beat is held
// by the receiver, the chain freezes; in_ready is high whenever the last
// cell is empty or is being drained, so bubbles are squeezed only at the end.
// Reset clears all valid bits and both key registers to zero.
module aes128_block_encrypt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  aes_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output aes_pkg::out_beat_t  out_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic [63:0]     key_high_reg;
    logic [63:0]     key_low_reg;
    logic            en;
    logic            entry_valid_reg;
    logic [127:0]    entry_state_reg;
    logic [127:0]    entry_rkey_reg;
    aes_pkg::stage_t chain [aes_pkg::NumRounds + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (aes_pkg::reg_index_t'(cfg_index))
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves when the last cell is free or is being read out.
    assign en       = !chain[aes_pkg::NumRounds].valid || out_ready;
    assign in_ready = en;

    // Entry cell: initial AddRoundKey with the cipher key itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_rkey_reg  <= {key_high_reg, key_low_reg};
            entry_state_reg <= {in_data.plain_high, in_data.plain_low}
                               ^ {key_high_reg, key_low_reg};
        end
    end

    assign chain[0] = {entry_valid_reg, entry_state_reg, entry_rkey_reg};

    for (genvar g = 1; g <= aes_pkg::NumRounds; g++)
    begin : g_round
        aes_round_cell #(.ROUND(4'(g))) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[g - 1]),
            .cur   (chain[g])
        );
    end

    // The high half of the state holds ciphertext bytes 0 to 7.
    assign out_valid = chain[aes_pkg::NumRounds].valid;
    assign out_data  = chain[aes_pkg::NumRounds].state;

endmodule

### rtl/aes_round_cell.sv
// One round cell of the AES-128 pipeline: round transform and next round key.
// Depends on aes_pkg.
module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  aes_pkg::stage_t prev,
    output aes_pkg::stage_t cur
);

    logic [127:0]    rk_next;
    logic [127:0]    ss;
    logic [127:0]    mc;
    logic [31:0]     t;
    logic            valid_reg;
    logic [127:0]    state_reg;
    logic [127:0]    rkey_reg;

    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, w3r;
        w0 = prev.rkey[127:96];
        w1 = prev.rkey[95:64];
        w2 = prev.rkey[63:32];
        w3 = prev.rkey[31:0];
        w3r = {aes_pkg::sbox(w3[23:16]) ^ aes_pkg::rcon(ROUND), aes_pkg::sbox(w3[15:8]),
               aes_pkg::sbox(w3[7:0]), aes_pkg::sbox(w3[31:24])};
        t = w0 ^ w3r;
        rk_next[127:96] = t;
        rk_next[95:64]  = t ^ w1;
        rk_next[63:32]  = t ^ w1 ^ w2;
        rk_next[31:0]   = t ^ w1 ^ w2 ^ w3;
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                ss[127 - 8 * (c * 4 + r) -: 8] =
                    aes_pkg::sbox(aes_pkg::byte_at(prev.state, ((c + r) % 4) * 4 + r));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3;
            a0 = aes_pkg::byte_at(ss, c * 4);
            a1 = aes_pkg::byte_at(ss, c * 4 + 1);
            a2 = aes_pkg::byte_at(ss, c * 4 + 2);
            a3 = aes_pkg::byte_at(ss, c * 4 + 3);
            mc[127 - 32 * c -: 8] = aes_pkg::dbl(a0) ^ aes_pkg::dbl(a1) ^ a1 ^ a2 ^ a3;
            mc[119 - 32 * c -: 8] = a0 ^ aes_pkg::dbl(a1) ^ aes_pkg::dbl(a2) ^ a2 ^ a3;
            mc[111 - 32 * c -: 8] = a0 ^ a1 ^ aes_pkg::dbl(a2) ^ aes_pkg::dbl(a3) ^ a3;
            mc[103 - 32 * c -: 8] = aes_pkg::dbl(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::dbl(a3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rkey_reg  <= rk_next;
            state_reg <= ((ROUND == 4'(aes_pkg::NumRounds)) ? ss : mc) ^ rk_next;
        end
    end

    assign cur = {valid_reg, state_reg, rkey_reg};

endmodule

### rtl/aes128_block_encrypt_checker.sv
// Port-level checker for the AES-128 encryption pipeline, bound to the top.
// Depends on aes_pkg.
module aes128_block_encrypt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input aes_pkg::out_beat_t out_data
);

    // A held output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // The chain only stalls when the output is blocked.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A beat accepted while the receiver then stays ready shows up at the
    // output once it has passed the entry cell and every round cell.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready [*10] |=> out_valid)
        else $error("output beat missing after pipeline latency");

    // An idle output with no input leaves ready high.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("ready low with empty output");

endmodule

bind aes128_block_encrypt aes128_block_encrypt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
